FILE: rtl/core/pqma_pkg.sv
// Package with the shared types, widths and codes of the quad matcher.
`timescale 1ns / 1ps

package pqma_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_QUADS = 64;
    localparam int ADDR_W    = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;
    localparam int COUNT_W   = $clog2(MAX_QUADS + 1);

    // Fixed field widths.
    localparam int FUNC_W  = 2;
    localparam int COORD_W = 16;
    localparam int AREA_W  = 24;
    localparam int INDEX_W = 6;

    // Exact arithmetic widths for the edge cross products.
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    // One table entry: x lanes, y lanes, area.
    localparam int LANES_W = 4 * COORD_W;
    localparam int ENTRY_W = 2 * LANES_W + AREA_W;

    // Command codes.
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic signed [COORD_W-1:0] x3;
        logic signed [COORD_W-1:0] y3;
        logic [AREA_W-1:0]         quad_area;
    } cmd_t;

    // Result beat.
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] best_index;
        logic [AREA_W-1:0]  best_area;
    } res_t;

    // Containment verdict for one table entry, leaving the edge test.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [ADDR_W-1:0] idx;
        logic [AREA_W-1:0] area;
    } cand_t;

endpackage

FILE: rtl/core/pqma_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module pqma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                              clk,
    input  logic                                              we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]      waddr,
    input  logic [WIDTH-1:0]                                  wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]      raddr,
    output logic [WIDTH-1:0]                                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/pqma_edge_test.sv
// Two-stage strict containment test of a point against one stored quad.
`timescale 1ns / 1ps

module pqma_edge_test (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [pqma_pkg::ADDR_W-1:0]     in_idx,
    input  logic [pqma_pkg::ENTRY_W-1:0]    entry,
    input  logic signed [pqma_pkg::COORD_W-1:0] px,
    input  logic signed [pqma_pkg::COORD_W-1:0] py,
    output logic                            active,
    output pqma_pkg::cand_t                 cand
);

    localparam int CW = pqma_pkg::COORD_W;
    localparam int LW = pqma_pkg::LANES_W;

    logic signed [pqma_pkg::PROD_W-1:0] p1_next [4];
    logic signed [pqma_pkg::PROD_W-1:0] p2_next [4];
    logic signed [pqma_pkg::PROD_W-1:0] p1_reg  [4];
    logic signed [pqma_pkg::PROD_W-1:0] p2_reg  [4];
    logic                               s1_valid_reg;
    logic [pqma_pkg::ADDR_W-1:0]        s1_idx_reg;
    logic [pqma_pkg::AREA_W-1:0]        s1_area_reg;
    logic                               hit_next;
    logic                               cand_valid_reg;
    logic                               cand_hit_reg;
    logic [pqma_pkg::ADDR_W-1:0]        cand_idx_reg;
    logic [pqma_pkg::AREA_W-1:0]        cand_area_reg;

    // Stage one: edge vectors and point offsets, then the two products per edge.
    always_comb
    begin
        logic signed [CW-1:0]                 vx [4];
        logic signed [CW-1:0]                 vy [4];
        logic signed [pqma_pkg::DIFF_W-1:0]   dxb;
        logic signed [pqma_pkg::DIFF_W-1:0]   dyb;
        logic signed [pqma_pkg::DIFF_W-1:0]   dxp;
        logic signed [pqma_pkg::DIFF_W-1:0]   dyp;
        for (int k = 0; k < 4; k++)
        begin
            vx[k] = $signed(entry[k*CW +: CW]);
            vy[k] = $signed(entry[LW + k*CW +: CW]);
        end
        for (int k = 0; k < 4; k++)
        begin
            dxb = pqma_pkg::DIFF_W'(vx[(k + 1) % 4]) - pqma_pkg::DIFF_W'(vx[k]);
            dyb = pqma_pkg::DIFF_W'(vy[(k + 1) % 4]) - pqma_pkg::DIFF_W'(vy[k]);
            dxp = pqma_pkg::DIFF_W'(px) - pqma_pkg::DIFF_W'(vx[k]);
            dyp = pqma_pkg::DIFF_W'(py) - pqma_pkg::DIFF_W'(vy[k]);
            p1_next[k] = dxb * dyp;
            p2_next[k] = dyb * dxp;
        end
    end

    // Stage two: cross products, zero and sign checks.
    always_comb
    begin
        logic signed [pqma_pkg::CROSS_W-1:0] xprod;
        logic                                any_zero;
        logic                                any_neg;
        logic                                all_neg;
        any_zero = 1'b0;
        any_neg  = 1'b0;
        all_neg  = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            xprod = pqma_pkg::CROSS_W'(p1_reg[k]) - pqma_pkg::CROSS_W'(p2_reg[k]);
            if (xprod == '0)
            begin
                any_zero = 1'b1;
            end
            any_neg = any_neg | xprod[pqma_pkg::CROSS_W-1];
            all_neg = all_neg & xprod[pqma_pkg::CROSS_W-1];
        end
        hit_next = !any_zero && (all_neg || !any_neg);
    end

    // Pipeline control bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= in_valid;
            cand_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            p1_reg[k] <= p1_next[k];
            p2_reg[k] <= p2_next[k];
        end
        s1_idx_reg    <= in_idx;
        s1_area_reg   <= entry[2*LW +: pqma_pkg::AREA_W];
        cand_hit_reg  <= hit_next;
        cand_idx_reg  <= s1_idx_reg;
        cand_area_reg <= s1_area_reg;
    end

    assign active = s1_valid_reg || cand_valid_reg;
    assign cand   = {cand_valid_reg, cand_hit_reg, cand_idx_reg, cand_area_reg};

endmodule

FILE: rtl/core/point_in_quad_min_area_match.sv
// Top level: quad table in RAM, scan engine and least-area selection.
// Clear and append never raise busy.
// A query holds busy from acceptance until its result: the scan issues every stored
// quad, then drains the edge test, and an empty table goes straight to the drain.
// The scan reads one table entry per cycle from the single RAM read port.
// Results cannot be stalled; done is high for exactly one cycle per query.
// Reset empties the table and idles the scan; RAM contents are not cleared.
`timescale 1ns / 1ps

module point_in_quad_min_area_match (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pqma_pkg::cmd_t  cmd,
    output logic            done,
    output pqma_pkg::res_t  res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    localparam int AW = pqma_pkg::ADDR_W;
    localparam int NW = pqma_pkg::COUNT_W;

    state_t                            state_reg;
    logic [NW-1:0]                     count_reg;
    logic [AW-1:0]                     scan_addr_reg;
    logic                              rd_valid_reg;
    logic [AW-1:0]                     rd_idx_reg;
    logic signed [pqma_pkg::COORD_W-1:0] px_reg;
    logic signed [pqma_pkg::COORD_W-1:0] py_reg;
    logic                              found_reg;
    logic [AW-1:0]                     best_idx_reg;
    logic [pqma_pkg::AREA_W-1:0]       best_area_reg;
    logic                              done_reg;
    pqma_pkg::res_t                    res_reg;

    logic                              accept;
    logic                              wr_en;
    logic [pqma_pkg::ENTRY_W-1:0]      wr_entry;
    logic [pqma_pkg::ENTRY_W-1:0]      rd_entry;
    logic                              last_issue;
    logic                              test_active;
    pqma_pkg::cand_t                   cand;
    logic                              better;

    // Command beat acceptance and table write.
    assign accept   = start && (state_reg == ST_IDLE);
    assign wr_en    = accept && (cmd.func == pqma_pkg::FUNC_APPEND)
                      && (count_reg != NW'(pqma_pkg::MAX_QUADS));
    assign wr_entry = {cmd.quad_area,
                       cmd.y3, cmd.y2, cmd.y1, cmd.y0,
                       cmd.x3, cmd.x2, cmd.x1, cmd.x0};

    pqma_ram #(
        .WIDTH (pqma_pkg::ENTRY_W),
        .DEPTH (pqma_pkg::MAX_QUADS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_entry),
        .raddr (scan_addr_reg),
        .rdata (rd_entry)
    );

    pqma_edge_test u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .entry    (rd_entry),
        .px       (px_reg),
        .py       (py_reg),
        .active   (test_active),
        .cand     (cand)
    );

    // Scan end and winner comparison.
    assign last_issue = (NW'(scan_addr_reg) + NW'(1)) == count_reg;
    assign better     = cand.valid && cand.hit
                        && (!found_reg || (cand.area < best_area_reg));

    // Sequencer, table count, best-so-far and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_area_reg <= '0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            done_reg     <= 1'b0;
            rd_valid_reg <= (state_reg == ST_SCAN);
            rd_idx_reg   <= scan_addr_reg;
            if (better)
            begin
                found_reg     <= 1'b1;
                best_idx_reg  <= cand.idx;
                best_area_reg <= cand.area;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd.func)
                            pqma_pkg::FUNC_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            pqma_pkg::FUNC_APPEND:
                            begin
                                if (wr_en)
                                begin
                                    count_reg <= count_reg + NW'(1);
                                end
                            end
                            pqma_pkg::FUNC_QUERY:
                            begin
                                px_reg        <= cmd.x0;
                                py_reg        <= cmd.y0;
                                scan_addr_reg <= '0;
                                found_reg     <= 1'b0;
                                best_idx_reg  <= '0;
                                best_area_reg <= '0;
                                state_reg     <= (count_reg == '0) ? ST_DRAIN : ST_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (last_issue)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        scan_addr_reg <= scan_addr_reg + AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_valid_reg && !test_active && !cand.valid)
                    begin
                        state_reg          <= ST_IDLE;
                        done_reg           <= 1'b1;
                        res_reg.found      <= found_reg;
                        res_reg.best_index <= pqma_pkg::INDEX_W'(best_idx_reg);
                        res_reg.best_area  <= best_area_reg;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

    // A result beat only closes a query that held busy.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding query");

    // An empty answer carries zero index and zero area.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res.found) |-> (res.best_index == '0 && res.best_area == '0))
        else $error("not-found result carries nonzero payload");

    // The table never holds more entries than it has rows.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(pqma_pkg::MAX_QUADS))
        else $error("quad count exceeds table depth");

    // The containment pipeline is empty whenever the block is idle.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (!rd_valid_reg && !test_active && !cand.valid))
        else $error("scan pipeline active while idle");

    // A scan never reads past the filled part of the table.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (NW'(scan_addr_reg) < count_reg))
        else $error("scan address beyond quad count");

endmodule
